// ===== hdl/hsdd_pkg.sv =====
// hsdd_pkg: shared types and constants for the hash-set duplicate detector.
// No dependencies; imported by hsdd_hash, hsdd_table and the top level.
package hsdd_pkg;

    // Generation tag: a slot belongs to the current list only when its tag matches.
    localparam int          GEN_W     = 8;
    localparam logic [7:0]  GEN_FIRST = 8'd1;
    localparam logic [7:0]  GEN_LAST  = 8'd255;

    // Multiplicative hash constant (golden ratio, 32 bits).
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    // Result bus: duplicate in bit 0, overflow in bit 1, zero filled.
    localparam int          OUT_TDATA_W = 8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_END
    } t_state;

    // Table access strobes for one cycle.
    typedef struct packed {
        logic rd_en;
        logic ins_en;
        logic clr_en;
    } t_tbl_cmd;

endpackage

// ===== hdl/hsdd_hash.sv =====
// hsdd_hash: slot index hash (fold, multiply, take top bits, reduce).
// Depends on hsdd_pkg (HASH_MULT).
module hsdd_hash import hsdd_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_index
);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [63:0]   w_wide;
    logic [31:0]   w_fold;
    logic [31:0]   r_prod;
    logic [31:0]   n_prod;
    logic [AW:0]   w_top;

    assign w_wide = 64'(i_value);
    assign w_fold = w_wide[31:0] ^ w_wide[63:32];
    assign n_prod = w_fold * HASH_MULT;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    // Top bits of the product; one subtract covers depths that are not a power of two.
    assign w_top = {1'b0, r_prod[31 -: AW]};

    always_comb begin
        if (w_top >= (AW+1)'(TABLE_DEPTH)) begin
            o_index = AW'(w_top - (AW+1)'(TABLE_DEPTH));
        end else begin
            o_index = w_top[AW-1:0];
        end
    end

endmodule

// ===== hdl/hsdd_table.sv =====
// hsdd_table: slot value and slot tag memories, one read and one write port each.
// Depends on hsdd_pkg (t_tbl_cmd, GEN_W). Read data is registered.
module hsdd_table import hsdd_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  t_tbl_cmd                       i_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  logic [VALUE_WIDTH-1:0]         i_wr_value,
    input  logic [GEN_W-1:0]               i_wr_gen,
    output logic [VALUE_WIDTH-1:0]         o_rd_value,
    output logic [GEN_W-1:0]               o_rd_gen
);
    logic [VALUE_WIDTH-1:0] r_val_mem [TABLE_DEPTH];
    logic [GEN_W-1:0]       r_gen_mem [TABLE_DEPTH];

    // Values: written on insert only, never cleared.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en) begin
            r_val_mem[i_wr_addr] <= i_wr_value;
        end
        if (i_cmd.rd_en) begin
            o_rd_value <= r_val_mem[i_rd_addr];
        end
    end

    // Tags: insert writes the list tag, the clearing sweep writes zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en || i_cmd.clr_en) begin
            r_gen_mem[i_wr_addr] <= i_cmd.ins_en ? i_wr_gen : '0;
        end
        if (i_cmd.rd_en) begin
            o_rd_gen <= r_gen_mem[i_rd_addr];
        end
    end

endmodule

// ===== hdl/hash_set_duplicate_detector_unit.sv =====
// Hash-set duplicate detector: one request per list element, one result per list.
// A looked-up element passes S_HASH, then one S_PROBE step per table read (at least one);
// no new element is taken until its lookup ends. Elements after a duplicate skip the
// lookup; a closing request or empty marker leads to S_END, which registers the result.
// Reset (i_rst_n low, synchronous) starts a tag clearing sweep over every slot
// with s_axis_tready low; the same sweep runs after every 255th list.
module hash_set_duplicate_detector_unit import hsdd_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input requests
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // [0 +: VALUE_WIDTH] value
    input  logic                                 s_axis_tlast,  // last element of the list
    input  logic                                 s_axis_tuser,  // empty_req
    // Results
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [OUT_TDATA_W-1:0]               m_axis_tdata   // [0] duplicate, [1] overflow
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state                 r_state,   n_state;
    logic [AW-1:0]          r_clr_idx, n_clr_idx;  // clearing sweep address
    logic [GEN_W-1:0]       r_gen,     n_gen;      // tag of the current list
    logic                   r_found,   n_found;    // sticky duplicate
    logic                   r_full,    n_full;     // sticky overflow
    logic [VALUE_WIDTH-1:0] r_value,   n_value;    // element under lookup
    logic                   r_ends,    n_ends;     // this request closes the list
    logic [AW-1:0]          r_pos,     n_pos;      // slot being probed
    logic [AW-1:0]          r_probe,   n_probe;    // probes done for this element
    logic                   r_m_valid, n_m_valid;
    logic                   r_m_dup,   n_m_dup;
    logic                   r_m_ovf,   n_m_ovf;

    logic                   w_accept;
    logic                   w_out_free;
    logic [AW-1:0]          w_hash_idx;
    logic [AW-1:0]          w_pos_next;
    t_tbl_cmd               w_cmd;
    logic [AW-1:0]          w_rd_addr;
    logic [AW-1:0]          w_wr_addr;
    logic [VALUE_WIDTH-1:0] w_rd_value;
    logic [GEN_W-1:0]       w_rd_gen;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    // Input is taken in IDLE even while a result waits in the output register;
    // only the list-closing step waits for that register to drain.
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r_m_ovf, r_m_dup};

    // Linear probing wraps at the end of the table.
    assign w_pos_next = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;

    // ---------------------------------------------------------------
    // Submodules
    // ---------------------------------------------------------------
    // Hash product is captured at accept, index is ready in S_HASH.
    hsdd_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_hash (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_value (s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_index (w_hash_idx)
    );

    hsdd_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_value (r_value),
        .i_wr_gen   (r_gen),
        .o_rd_value (w_rd_value),
        .o_rd_gen   (w_rd_gen)
    );

    assign w_rd_addr = (r_state == S_HASH) ? w_hash_idx : w_pos_next;
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr_idx : r_pos;

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_gen     <= GEN_FIRST;
            r_found   <= 1'b0;
            r_full    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_gen     <= n_gen;
            r_found   <= n_found;
            r_full    <= n_full;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload, no reset needed.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_ends  <= n_ends;
        r_pos   <= n_pos;
        r_probe <= n_probe;
        r_m_dup <= n_m_dup;
        r_m_ovf <= n_m_ovf;
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_gen     = r_gen;
        n_found   = r_found;
        n_full    = r_full;
        n_value   = r_value;
        n_ends    = r_ends;
        n_pos     = r_pos;
        n_probe   = r_probe;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_dup   = r_m_dup;
        n_m_ovf   = r_m_ovf;
        w_cmd     = '0;

        unique case (r_state)
            S_CLEAR: begin
                // One tag per cycle back to zero.
                w_cmd.clr_en = 1'b1;
                if (r_clr_idx == LAST_SLOT) begin
                    n_clr_idx = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_value = s_axis_tdata[VALUE_WIDTH-1:0];
                    n_ends  = s_axis_tlast || s_axis_tuser;
                    if (!s_axis_tuser && !r_found) begin
                        n_state = S_HASH;
                    end else if (s_axis_tlast || s_axis_tuser) begin
                        n_state = S_END;
                    end
                end
            end
            S_HASH: begin
                w_cmd.rd_en = 1'b1;
                n_pos       = w_hash_idx;
                n_probe     = '0;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                if (w_rd_gen != r_gen) begin
                    // Free slot: claim it for this list.
                    w_cmd.ins_en = 1'b1;
                    n_state      = r_ends ? S_END : S_IDLE;
                end else if (w_rd_value == r_value) begin
                    n_found = 1'b1;
                    n_state = r_ends ? S_END : S_IDLE;
                end else if (r_probe == LAST_SLOT) begin
                    // Whole table visited, value dropped.
                    n_full  = 1'b1;
                    n_state = r_ends ? S_END : S_IDLE;
                end else begin
                    w_cmd.rd_en = 1'b1;
                    n_pos       = w_pos_next;
                    n_probe     = r_probe + 1'b1;
                end
            end
            S_END: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_dup   = r_found;
                    n_m_ovf   = r_full;
                    n_found   = 1'b0;
                    n_full    = 1'b0;
                    // New tag empties the set; tag wrap needs a full sweep.
                    if (r_gen == GEN_LAST) begin
                        n_gen     = GEN_FIRST;
                        n_clr_idx = '0;
                        n_state   = S_CLEAR;
                    end else begin
                        n_gen   = r_gen + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

`ifndef SYNTH
    // Tag zero marks a free slot and must never be the live list tag.
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("list tag is zero");

    // Every result closes the list with a fresh tag.
    a_gen_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && w_out_free) |=> (r_gen != $past(r_gen)))
        else $error("tag not advanced after result");

    // Overflow is raised only after the last possible probe.
    a_full_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && !r_full) ##1 r_full |-> ($past(r_probe) == LAST_SLOT))
        else $error("overflow before full scan");

    // Sweep and insert share the tag write port.
    a_one_tag_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.ins_en && w_cmd.clr_en))
        else $error("tag write conflict");
`endif

endmodule
